@@ design/qrao_pkg.sv @@
package qrao_pkg;

  localparam int COEF_W = 32;
  localparam int FRAC_W = 16;
  localparam int TOL_W  = 31;
  localparam int ORD_W  = 3;
  localparam int ST_W   = 3;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam int PROD_W = 2 * COEF_W;
  localparam int D_W    = 2 * COEF_W + 2;
  localparam int ROOT_W = COEF_W + 1;
  localparam int SQR_W  = ROOT_W + 3;
  localparam int DEN_W  = COEF_W + 1;
  localparam int BASE_W = COEF_W + 1;
  localparam int NUM_W  = COEF_W + 3;
  localparam int NMAG_W = COEF_W + 2;
  localparam int DVD_W  = NMAG_W + FRAC_W;

  localparam logic [ST_W-1:0] ST_TWO    = 3'd0;
  localparam logic [ST_W-1:0] ST_DOUBLE = 3'd1;
  localparam logic [ST_W-1:0] ST_NOREAL = 3'd2;
  localparam logic [ST_W-1:0] ST_LINEAR = 3'd3;
  localparam logic [ST_W-1:0] ST_INF    = 3'd4;
  localparam logic [ST_W-1:0] ST_NONE   = 3'd5;

  localparam logic [ORD_W-1:0] ORD_ABC = 3'd0;
  localparam logic [ORD_W-1:0] ORD_ACB = 3'd1;
  localparam logic [ORD_W-1:0] ORD_BAC = 3'd2;
  localparam logic [ORD_W-1:0] ORD_BCA = 3'd3;
  localparam logic [ORD_W-1:0] ORD_CAB = 3'd4;
  localparam logic [ORD_W-1:0] ORD_CBA = 3'd5;

  localparam logic [TOL_W-1:0] TOL_RESET = 31'd1;
  localparam logic [0:0] REG_TOL = 1'b0;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
  } in_t;

  typedef struct packed {
    logic [ORD_W-1:0]         ordering;
    logic [ST_W-1:0]          status;
    logic signed [COEF_W-1:0] root_one;
    logic signed [COEF_W-1:0] root_two;
    logic                     saturated;
    logic                     last;
  } out_t;

  typedef struct packed {
    logic [ORD_W-1:0]  ordering;
    logic              last;
    logic [ST_W-1:0]   status;
    logic [DEN_W-1:0]  den;
    logic              den_neg;
    logic [BASE_W-1:0] base;
    logic              use_s;
  } sq_side_t;

  typedef struct packed {
    logic [ORD_W-1:0] ordering;
    logic             last;
    logic [ST_W-1:0]  status;
    logic             neg1;
    logic             neg2;
    logic             zero1;
    logic             zero2;
    logic [DEN_W-1:0] den;
  } dv_side_t;

endpackage

@@ design/qrao_sqrt_cell.sv @@
module qrao_sqrt_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     valid_in,
  input  logic [qrao_pkg::D_W-1:0]    d_in,
  input  logic [qrao_pkg::ROOT_W-1:0] root_in,
  input  logic [qrao_pkg::SQR_W-1:0]  rem_in,
  input  qrao_pkg::sq_side_t       side_in,
  output logic                     valid_out,
  output logic [qrao_pkg::D_W-1:0]    d_out,
  output logic [qrao_pkg::ROOT_W-1:0] root_out,
  output logic [qrao_pkg::SQR_W-1:0]  rem_out,
  output qrao_pkg::sq_side_t       side_out
);
  import qrao_pkg::*;

  logic [SQR_W-1:0] rem_sh;
  logic [SQR_W-1:0] trial;
  logic             fits;

  assign rem_sh = {rem_in[SQR_W-3:0], d_in[D_W-1 -: 2]};
  assign trial  = {1'b0, root_in, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out    <= {d_in[D_W-3:0], 2'b00};
      root_out <= {root_in[ROOT_W-2:0], fits};
      rem_out  <= fits ? rem_sh - trial : rem_sh;
      side_out <= side_in;
    end
  end

endmodule

@@ design/qrao_div_cell.sv @@
module qrao_div_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      valid_in,
  input  logic [qrao_pkg::DVD_W-1:0] n1_in,
  input  logic [qrao_pkg::DVD_W-1:0] n2_in,
  input  logic [qrao_pkg::DEN_W-1:0] r1_in,
  input  logic [qrao_pkg::DEN_W-1:0] r2_in,
  input  logic [qrao_pkg::DVD_W-1:0] q1_in,
  input  logic [qrao_pkg::DVD_W-1:0] q2_in,
  input  qrao_pkg::dv_side_t        side_in,
  output logic                      valid_out,
  output logic [qrao_pkg::DVD_W-1:0] n1_out,
  output logic [qrao_pkg::DVD_W-1:0] n2_out,
  output logic [qrao_pkg::DEN_W-1:0] r1_out,
  output logic [qrao_pkg::DEN_W-1:0] r2_out,
  output logic [qrao_pkg::DVD_W-1:0] q1_out,
  output logic [qrao_pkg::DVD_W-1:0] q2_out,
  output qrao_pkg::dv_side_t        side_out
);
  import qrao_pkg::*;

  logic [DEN_W:0] rem_sh1;
  logic [DEN_W:0] rem_sh2;
  logic [DEN_W:0] diff1;
  logic [DEN_W:0] diff2;
  logic           ge1;
  logic           ge2;

  assign rem_sh1 = {r1_in, n1_in[DVD_W-1]};
  assign rem_sh2 = {r2_in, n2_in[DVD_W-1]};
  assign ge1     = rem_sh1 >= {1'b0, side_in.den};
  assign ge2     = rem_sh2 >= {1'b0, side_in.den};
  assign diff1   = rem_sh1 - {1'b0, side_in.den};
  assign diff2   = rem_sh2 - {1'b0, side_in.den};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_out   <= {n1_in[DVD_W-2:0], 1'b0};
      n2_out   <= {n2_in[DVD_W-2:0], 1'b0};
      r1_out   <= ge1 ? diff1[DEN_W-1:0] : rem_sh1[DEN_W-1:0];
      r2_out   <= ge2 ? diff2[DEN_W-1:0] : rem_sh2[DEN_W-1:0];
      q1_out   <= {q1_in[DVD_W-2:0], ge1};
      q2_out   <= {q2_in[DVD_W-2:0], ge2};
      side_out <= side_in;
    end
  end

endmodule

@@ design/quadratic_roots_all_orders_unit.sv @@
// each ordering passes stages 1 and 2, the square root cells, the divider cells and the
// output register; the pipeline takes one ordering and gives one result per cycle unless
// stalled; a new input waits until the last of its predecessor's six orderings issues
// reset: synchronous, clears all valid flags and the front sequencer, tolerance back to 1
module quadratic_roots_all_orders_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  qrao_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output qrao_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qrao_pkg::ADDR_W-1:0]   paddr,
  input  logic [qrao_pkg::DATA_W-1:0]   pwdata,
  output logic [qrao_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import qrao_pkg::*;

  logic             en;
  logic             in_take;
  logic [TOL_W-1:0] tolerance;

  // front sequencer
  in_t              hold;
  logic             busy;
  logic [ORD_W-1:0] cnt;
  logic signed [COEF_W-1:0] sel_p, sel_q, sel_r;

  // stage 1
  logic                     v1;
  logic [ORD_W-1:0]         ord1;
  logic                     last1;
  logic signed [COEF_W-1:0] p1, q1, r1;

  // stage 2
  logic              v2;
  logic [ORD_W-1:0]  ord2;
  logic              last2;
  logic [COEF_W-1:0] pm2, qm2, rm2;
  logic              pneg2, qneg2, rneg2;
  logic              psm2, qsm2, rsm2;
  logic [PROD_W-1:0] qq2, pr2;
  logic [COEF_W-1:0] pm1, qm1, rm1;

  // stage 3 logic
  logic [D_W-1:0]  qq_x, pr4, dmag, tol_d;
  logic            dneg, dz;
  logic [ST_W-1:0] st3;
  sq_side_t        side3;

  // square root chain
  logic               sq_v    [0:ROOT_W];
  logic [D_W-1:0]     sq_d    [0:ROOT_W];
  logic [ROOT_W-1:0]  sq_root [0:ROOT_W];
  logic [SQR_W-1:0]   sq_rem  [0:ROOT_W];
  sq_side_t           sq_side [0:ROOT_W];

  // numerator forming
  logic [NUM_W-1:0]  base_x, s_x, n1, n2;
  logic [NUM_W-1:0]  n1m, n2m;
  dv_side_t          dside;

  // divider chain
  logic              dv_v    [0:DVD_W];
  logic [DVD_W-1:0]  dv_n1   [0:DVD_W];
  logic [DVD_W-1:0]  dv_n2   [0:DVD_W];
  logic [DEN_W-1:0]  dv_r1   [0:DVD_W];
  logic [DEN_W-1:0]  dv_r2   [0:DVD_W];
  logic [DVD_W-1:0]  dv_q1   [0:DVD_W];
  logic [DVD_W-1:0]  dv_q2   [0:DVD_W];
  dv_side_t          dv_side [0:DVD_W];

  // final clip
  dv_side_t          fs;
  logic              has1, has2, sat1, sat2;
  logic [DVD_W-1:0]  lim1, lim2;
  logic [COEF_W-1:0] val1, val2;
  out_t              res;

  assign en = !(out_valid && out_stall);

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_TOL) ? DATA_W'(tolerance) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (psel && penable && pwrite && paddr[ADDR_W-1] == REG_TOL) begin
      tolerance <= pwdata[TOL_W-1:0];
    end
  end

  // front: one ordering per cycle while the output is not stalled
  assign in_stall = busy && !(en && cnt == ORD_CBA);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= ORD_ABC;
    end else if (!busy) begin
      busy <= in_take;
      cnt  <= ORD_ABC;
    end else if (en) begin
      if (cnt == ORD_CBA) begin
        busy <= in_take;
        cnt  <= ORD_ABC;
      end else begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold <= in_data;
    end
  end

  always_comb begin
    unique case (cnt)
      ORD_ABC: begin
        sel_p = hold.coef_a; sel_q = hold.coef_b; sel_r = hold.coef_c;
      end
      ORD_ACB: begin
        sel_p = hold.coef_a; sel_q = hold.coef_c; sel_r = hold.coef_b;
      end
      ORD_BAC: begin
        sel_p = hold.coef_b; sel_q = hold.coef_a; sel_r = hold.coef_c;
      end
      ORD_BCA: begin
        sel_p = hold.coef_b; sel_q = hold.coef_c; sel_r = hold.coef_a;
      end
      ORD_CAB: begin
        sel_p = hold.coef_c; sel_q = hold.coef_a; sel_r = hold.coef_b;
      end
      ORD_CBA: begin
        sel_p = hold.coef_c; sel_q = hold.coef_b; sel_r = hold.coef_a;
      end
      default: begin
        sel_p = '0; sel_q = '0; sel_r = '0;
      end
    endcase
  end

  // stage 1: selected ordering
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ord1  <= cnt;
      last1 <= cnt == ORD_CBA;
      p1    <= sel_p;
      q1    <= sel_q;
      r1    <= sel_r;
    end
  end

  // stage 2: magnitudes and products
  assign pm1 = p1[COEF_W-1] ? COEF_W'(-p1) : COEF_W'(p1);
  assign qm1 = q1[COEF_W-1] ? COEF_W'(-q1) : COEF_W'(q1);
  assign rm1 = r1[COEF_W-1] ? COEF_W'(-r1) : COEF_W'(r1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ord2  <= ord1;
      last2 <= last1;
      pm2   <= pm1;
      qm2   <= qm1;
      rm2   <= rm1;
      pneg2 <= p1[COEF_W-1];
      qneg2 <= q1[COEF_W-1];
      rneg2 <= r1[COEF_W-1];
      psm2  <= pm1 < COEF_W'(tolerance);
      qsm2  <= qm1 < COEF_W'(tolerance);
      rsm2  <= rm1 < COEF_W'(tolerance);
      qq2   <= qm1 * qm1;
      pr2   <= pm1 * rm1;
    end
  end

  // stage 3: discriminant and classification
  assign qq_x  = D_W'(qq2);
  assign pr4   = {pr2, 2'b00};
  assign tol_d = D_W'({tolerance, {FRAC_W{1'b0}}});

  always_comb begin
    dneg = 1'b0;
    if (pneg2 != rneg2) begin
      dmag = qq_x + pr4;
    end else if (qq_x >= pr4) begin
      dmag = qq_x - pr4;
    end else begin
      dmag = pr4 - qq_x;
      dneg = 1'b1;
    end
  end

  assign dz = dmag < tol_d;

  always_comb begin
    if (psm2) begin
      if (qsm2) begin
        st3 = rsm2 ? ST_INF : ST_NONE;
      end else begin
        st3 = ST_LINEAR;
      end
    end else if (dz) begin
      st3 = ST_DOUBLE;
    end else if (!dneg && dmag != '0) begin
      st3 = ST_TWO;
    end else begin
      st3 = ST_NOREAL;
    end
  end

  always_comb begin
    side3.ordering = ord2;
    side3.last     = last2;
    side3.status   = st3;
    side3.use_s    = st3 == ST_TWO;
    if (st3 == ST_LINEAR) begin
      side3.den     = {1'b0, qm2};
      side3.den_neg = qneg2;
      side3.base    = rneg2 ? {1'b0, rm2} : BASE_W'(-{1'b0, rm2});
    end else begin
      side3.den     = {pm2, 1'b0};
      side3.den_neg = pneg2;
      side3.base    = qneg2 ? {1'b0, qm2} : BASE_W'(-{1'b0, qm2});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_d[0]    <= dmag;
      sq_root[0] <= '0;
      sq_rem[0]  <= '0;
      sq_side[0] <= side3;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    qrao_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (sq_v[k]),
      .d_in      (sq_d[k]),
      .root_in   (sq_root[k]),
      .rem_in    (sq_rem[k]),
      .side_in   (sq_side[k]),
      .valid_out (sq_v[k+1]),
      .d_out     (sq_d[k+1]),
      .root_out  (sq_root[k+1]),
      .rem_out   (sq_rem[k+1]),
      .side_out  (sq_side[k+1])
    );
  end

  // numerators
  assign base_x = {{2{sq_side[ROOT_W].base[BASE_W-1]}}, sq_side[ROOT_W].base};
  assign s_x    = {2'b00, sq_root[ROOT_W]};
  assign n1     = sq_side[ROOT_W].use_s ? base_x + s_x : base_x;
  assign n2     = base_x - s_x;
  assign n1m    = n1[NUM_W-1] ? -n1 : n1;
  assign n2m    = n2[NUM_W-1] ? -n2 : n2;

  always_comb begin
    dside.ordering = sq_side[ROOT_W].ordering;
    dside.last     = sq_side[ROOT_W].last;
    dside.status   = sq_side[ROOT_W].status;
    dside.neg1     = n1[NUM_W-1] ^ sq_side[ROOT_W].den_neg;
    dside.neg2     = n2[NUM_W-1] ^ sq_side[ROOT_W].den_neg;
    dside.zero1    = n1 == '0;
    dside.zero2    = n2 == '0;
    dside.den      = sq_side[ROOT_W].den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_n1[0]   <= {n1m[NMAG_W-1:0], {FRAC_W{1'b0}}};
      dv_n2[0]   <= {n2m[NMAG_W-1:0], {FRAC_W{1'b0}}};
      dv_r1[0]   <= '0;
      dv_r2[0]   <= '0;
      dv_q1[0]   <= '0;
      dv_q2[0]   <= '0;
      dv_side[0] <= dside;
    end
  end

  for (genvar k = 0; k < DVD_W; k++) begin : g_div
    qrao_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (dv_v[k]),
      .n1_in     (dv_n1[k]),
      .n2_in     (dv_n2[k]),
      .r1_in     (dv_r1[k]),
      .r2_in     (dv_r2[k]),
      .q1_in     (dv_q1[k]),
      .q2_in     (dv_q2[k]),
      .side_in   (dv_side[k]),
      .valid_out (dv_v[k+1]),
      .n1_out    (dv_n1[k+1]),
      .n2_out    (dv_n2[k+1]),
      .r1_out    (dv_r1[k+1]),
      .r2_out    (dv_r2[k+1]),
      .q1_out    (dv_q1[k+1]),
      .q2_out    (dv_q2[k+1]),
      .side_out  (dv_side[k+1])
    );
  end

  // clip and pack, a zero numerator gives a zero root
  assign fs   = dv_side[DVD_W];
  assign has1 = fs.status == ST_TWO || fs.status == ST_DOUBLE || fs.status == ST_LINEAR;
  assign has2 = fs.status == ST_TWO;
  assign lim1 = fs.neg1 ? DVD_W'({1'b1, {(COEF_W-1){1'b0}}}) : DVD_W'({(COEF_W-1){1'b1}});
  assign lim2 = fs.neg2 ? DVD_W'({1'b1, {(COEF_W-1){1'b0}}}) : DVD_W'({(COEF_W-1){1'b1}});
  assign sat1 = has1 && !fs.zero1 && dv_q1[DVD_W] > lim1;
  assign sat2 = has2 && !fs.zero2 && dv_q2[DVD_W] > lim2;

  always_comb begin
    if (!has1 || fs.zero1) begin
      val1 = '0;
    end else if (sat1) begin
      val1 = fs.neg1 ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      val1 = fs.neg1 ? COEF_W'(-dv_q1[DVD_W]) : dv_q1[DVD_W][COEF_W-1:0];
    end
    if (!has2 || fs.zero2) begin
      val2 = '0;
    end else if (sat2) begin
      val2 = fs.neg2 ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      val2 = fs.neg2 ? COEF_W'(-dv_q2[DVD_W]) : dv_q2[DVD_W][COEF_W-1:0];
    end
  end

  always_comb begin
    res.ordering  = fs.ordering;
    res.status    = fs.status;
    res.root_one  = val1;
    res.root_two  = val2;
    res.saturated = sat1 || sat2;
    res.last      = fs.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v[DVD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res;
    end
  end

  a_last_is_cba: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> out_data.ordering == ORD_CBA)
    else $error("last flag on wrong ordering");

  a_no_roots: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_NOREAL || out_data.status == ST_INF ||
                  out_data.status == ST_NONE)
    |-> out_data.root_one == '0 && out_data.root_two == '0 && !out_data.saturated)
    else $error("root reported without a solution");

  a_second_root: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_TWO |-> out_data.root_two == '0)
    else $error("second root outside two-root case");

  a_seq_order: assert property (@(posedge clk) disable iff (rst)
    busy && en && cnt != ORD_CBA |=> busy && cnt == $past(cnt) + 3'd1)
    else $error("ordering sequencer skipped");

endmodule
